// File: rtl/cesu_pkg.sv
// ----------------------------------------------------------------------------
// CESU-8 fixer package
// Shared constants and the command type passed from the front end to the
// byte emitter.
// ----------------------------------------------------------------------------
package cesu_pkg;

    localparam int BYTE_W      = 8;
    localparam int HOLD_DEPTH  = 5;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAIR_LEAD   = 8'hED;
    localparam logic [7:0] PAIR_SECOND = 8'hA0;
    localparam logic [7:0] HIGH_NIBBLE = 8'hF0;
    localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] LOW_SIX     = 8'h3F;
    localparam logic [7:0] UTF8_LEAD4  = 8'hF0;
    localparam logic [7:0] UTF8_CONT   = 8'h80;
    localparam logic [20:0] PLANE_BASE = 21'h10000;

    // One front-end decision: up to five bytes to emit, in order.
    typedef struct packed {
        logic                                 last;
        logic [CNT_W-1:0]                     cnt;
        logic [HOLD_DEPTH-1:0][BYTE_W-1:0]    data;
    } cesu_cmd_t;

endpackage

// File: rtl/cesu_front.sv
// ----------------------------------------------------------------------------
// CESU-8 fixer front end
// Accepts input beats, tracks a candidate surrogate pair and issues one
// command per beat that has bytes to emit.
// ----------------------------------------------------------------------------
module cesu_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    input  logic                      q_full,
    output logic                      push,
    output cesu_pkg::cesu_cmd_t       cmd
);

    logic [cesu_pkg::CNT_W-1:0]  count_reg;
    logic [cesu_pkg::CNT_W-1:0]  count_next;
    logic [7:0]                  held_reg [cesu_pkg::HOLD_DEPTH];
    logic                        hold_en;
    logic [cesu_pkg::CNT_W-1:0]  hold_idx;
    logic                        accept;
    logic [9:0]                  high10;
    logic [9:0]                  low10;
    logic [20:0]                 cp;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && (cmd.cnt != '0);

    assign high10 = {held_reg[1][3:0], held_reg[2][5:0]};
    assign low10  = {held_reg[4][3:0], in_byte[5:0]};
    assign cp     = cesu_pkg::PLANE_BASE + {1'b0, high10, low10};

    always_comb
    begin
        cmd.last   = in_last;
        cmd.cnt    = '0;
        cmd.data   = '0;
        hold_en    = 1'b0;
        hold_idx   = '0;
        count_next = count_reg;
        if (count_reg >= cesu_pkg::CNT_W'(cesu_pkg::HOLD_DEPTH))
        begin
            // Sixth byte of a pair: emit the four-byte UTF-8 form.
            cmd.data[0] = cesu_pkg::UTF8_LEAD4 | {5'b0, cp[20:18]};
            cmd.data[1] = cesu_pkg::UTF8_CONT | ({2'b0, cp[17:12]} & cesu_pkg::LOW_SIX);
            cmd.data[2] = cesu_pkg::UTF8_CONT | ({2'b0, cp[11:6]} & cesu_pkg::LOW_SIX);
            cmd.data[3] = cesu_pkg::UTF8_CONT | ({2'b0, cp[5:0]} & cesu_pkg::LOW_SIX);
            cmd.cnt     = 3'd4;
            count_next  = '0;
        end
        else if (count_reg >= 3'd2)
        begin
            hold_en  = 1'b1;
            hold_idx = count_reg;
            if (in_last)
            begin
                for (int i = 0; i < cesu_pkg::HOLD_DEPTH; i++)
                begin
                    cmd.data[i] = (3'(i) < count_reg) ? held_reg[i] : in_byte;
                end
                cmd.cnt    = count_reg + 3'd1;
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 3'd1;
            end
        end
        else if (count_reg == 3'd1 &&
                 (in_byte & cesu_pkg::HIGH_NIBBLE) == cesu_pkg::PAIR_SECOND)
        begin
            hold_en  = 1'b1;
            hold_idx = 3'd1;
            if (in_last)
            begin
                cmd.data[0] = held_reg[0];
                cmd.data[1] = in_byte;
                cmd.cnt     = 3'd2;
                count_next  = '0;
            end
            else
            begin
                count_next = 3'd2;
            end
        end
        else
        begin
            // A broken pair start releases the held lead byte first, then the
            // new byte is judged as if nothing were held.
            if (in_byte == cesu_pkg::PAIR_LEAD && !in_last)
            begin
                hold_en    = 1'b1;
                hold_idx   = '0;
                count_next = 3'd1;
                if (count_reg == 3'd1)
                begin
                    cmd.data[0] = held_reg[0];
                    cmd.cnt     = 3'd1;
                end
            end
            else
            begin
                count_next = '0;
                if (count_reg == 3'd1)
                begin
                    cmd.data[0] = held_reg[0];
                    cmd.data[1] = in_byte;
                    cmd.cnt     = 3'd2;
                end
                else
                begin
                    cmd.data[0] = in_byte;
                    cmd.cnt     = 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < cesu_pkg::HOLD_DEPTH; i++)
        begin
            if (accept && hold_en && hold_idx == 3'(i))
            begin
                held_reg[i] <= in_byte;
            end
        end
    end

endmodule

// File: rtl/cesu_queue.sv
// ----------------------------------------------------------------------------
// CESU-8 fixer command queue
// Small FIFO that decouples the front end from the byte emitter.
// ----------------------------------------------------------------------------
module cesu_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  cesu_pkg::cesu_cmd_t       push_cmd,
    output logic                      full,
    input  logic                      pop,
    output logic                      empty,
    output cesu_pkg::cesu_cmd_t       head
);

    cesu_pkg::cesu_cmd_t          fifo_mem_reg [cesu_pkg::QUEUE_DEPTH];
    logic [cesu_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [cesu_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [cesu_pkg::QCNT_W-1:0]  fill_reg;
    logic [cesu_pkg::QCNT_W-1:0]  fill_next;

    assign full  = (fill_reg == cesu_pkg::QCNT_W'(cesu_pkg::QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = fifo_mem_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/cesu_back.sv
// ----------------------------------------------------------------------------
// CESU-8 fixer byte emitter
// Walks the bytes of the command at the queue head, one output beat each.
// ----------------------------------------------------------------------------
module cesu_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      empty,
    input  cesu_pkg::cesu_cmd_t       head,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic                      out_last
);

    logic [cesu_pkg::CNT_W-1:0]  idx_reg;
    logic                        final_byte;
    logic                        take;

    assign out_valid  = !empty;
    assign take       = out_valid && out_ready;
    assign final_byte = (idx_reg + 3'd1) == head.cnt;
    assign out_byte   = head.data[idx_reg];
    assign out_last   = head.last && final_byte;
    assign pop        = take && final_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (take)
        begin
            idx_reg <= final_byte ? '0 : idx_reg + 3'd1;
        end
    end

endmodule

// File: rtl/cesu8_to_utf8_surrogate_fixer.sv
// A byte that passes through is registered in the command queue before it reaches the output.
// Throughput: one input beat per cycle and, while the receiver is ready, one output beat per cycle;
// a pair flushed at end of stream gives up to five output bytes, absorbed by a four-entry queue.
// Input stalls only when that queue between front end and emitter is full.
// Reset (rst_n low, asynchronous) empties the queue and drops any held pair bytes.
// ----------------------------------------------------------------------------
// CESU-8 to UTF-8 surrogate fixer
// Rewrites six-byte CESU-8 surrogate pairs as four-byte UTF-8 sequences.
// ----------------------------------------------------------------------------
module cesu8_to_utf8_surrogate_fixer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);

    cesu_pkg::cesu_cmd_t  push_cmd;
    cesu_pkg::cesu_cmd_t  head_cmd;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;

    cesu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    cesu_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    cesu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head_cmd),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: verif/tb_cesu8_to_utf8_surrogate_fixer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the CESU-8 to UTF-8 surrogate fixer
// Drives byte frames, directed and random, into the slave stream and checks
// every master beat against a behavioral predictor of the pair rewrite and
// the end-of-frame flush. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_cesu8_to_utf8_surrogate_fixer;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;

    // Predictor state: bytes of a candidate surrogate pair held so far.
    logic [2:0] hold_cnt = 3'd0;
    logic [7:0] hold_buf [cesu_pkg::HOLD_DEPTH];

    utf8_beat_t utf8_expect_q [$];
    logic [7:0] frame_q [$];
    int         fails = 0;
    int         bytes_sent = 0;
    bit         src_free = 1'b0;
    bit         sink_free = 1'b0;
    int         ready_left = 0;

    cesu8_to_utf8_surrogate_fixer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Works out the output beats caused by one accepted input beat.
    task automatic predict_fixed_bytes(input logic [7:0] b, input logic lst);
        logic [7:0]  outs [5];
        int          n;
        bit          fresh;
        logic [9:0]  hi10;
        logic [9:0]  lo10;
        logic [20:0] cp;
        utf8_beat_t  beat;
        n = 0;
        if (hold_cnt >= cesu_pkg::HOLD_DEPTH)
        begin
            hi10 = {hold_buf[1][3:0], hold_buf[2][5:0]};
            lo10 = {hold_buf[4][3:0], b[5:0]};
            cp = cesu_pkg::PLANE_BASE + {1'b0, hi10, lo10};
            outs[0] = cesu_pkg::UTF8_LEAD4 | {5'd0, cp[20:18]};
            outs[1] = cesu_pkg::UTF8_CONT | {2'd0, cp[17:12]};
            outs[2] = cesu_pkg::UTF8_CONT | {2'd0, cp[11:6]};
            outs[3] = cesu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
            n = 4;
            hold_cnt = 3'd0;
        end
        else if (hold_cnt >= 3'd2)
        begin
            hold_buf[hold_cnt] = b;
            hold_cnt = hold_cnt + 3'd1;
            if (lst)
            begin
                for (int i = 0; i < hold_cnt; i++)
                begin
                    outs[n] = hold_buf[i];
                    n = n + 1;
                end
                hold_cnt = 3'd0;
            end
        end
        else
        begin
            fresh = 1'b1;
            if (hold_cnt == 3'd1)
            begin
                if ((b & cesu_pkg::HIGH_NIBBLE) == cesu_pkg::PAIR_SECOND)
                begin
                    hold_buf[1] = b;
                    hold_cnt = 3'd2;
                    fresh = 1'b0;
                    if (lst)
                    begin
                        outs[0] = hold_buf[0];
                        outs[1] = hold_buf[1];
                        n = 2;
                        hold_cnt = 3'd0;
                    end
                end
                else
                begin
                    outs[n] = hold_buf[0];
                    n = n + 1;
                    hold_cnt = 3'd0;
                end
            end
            if (fresh)
            begin
                // A lead byte on the final beat cannot start a pair.
                if (b == cesu_pkg::PAIR_LEAD && !lst)
                begin
                    hold_buf[0] = b;
                    hold_cnt = 3'd1;
                end
                else
                begin
                    outs[n] = b;
                    n = n + 1;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            beat.data = outs[i];
            beat.last = lst && (i == n - 1);
            utf8_expect_q.push_back(beat);
        end
    endtask

    // Input beats are predicted and output beats checked at the same edge.
    always @(posedge clk)
    begin : monitor
        utf8_beat_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_fixed_bytes(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (utf8_expect_q.size() == 0)
                begin
                    $error("unexpected output beat: out_byte=%02h out_last=%0b",
                           m_axis_tdata, m_axis_tlast);
                    fails++;
                end
                else
                begin
                    want = utf8_expect_q.pop_front();
                    if (want.data !== m_axis_tdata)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.data, m_axis_tdata);
                        fails++;
                    end
                    if (want.last !== m_axis_tlast)
                    begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.last, m_axis_tlast);
                        fails++;
                    end
                end
            end
        end
    end

    // Receiver back-pressure: runs of ready, mostly short stalls, a few long ones.
    always @(posedge clk)
    begin : sink_stall
        int r;
        if (sink_free)
        begin
            m_axis_tready <= 1'b1;
            ready_left <= 0;
        end
        else if (ready_left > 0)
        begin
            ready_left <= ready_left - 1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                m_axis_tready <= 1'b1;
                ready_left <= $urandom_range(0, 12);
            end
            else if (r < 92)
            begin
                m_axis_tready <= 1'b0;
                ready_left <= $urandom_range(0, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_left <= $urandom_range(8, 40);
            end
        end
    end

    function automatic int source_gap();
        int r;
        if (src_free)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    // Valid stays high across back-to-back beats; it only drops for a gap.
    task automatic send_byte(input logic [7:0] v, input logic lst);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= lst;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        bytes_sent++;
        gap = source_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame_q();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // Holds the sender off until every predicted beat has left the block.
    // It first waits on the clock so that the last accepted beat is predicted.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (utf8_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void append_pair(input int keep);
        logic [7:0] p [6];
        p[0] = cesu_pkg::PAIR_LEAD;
        p[1] = cesu_pkg::PAIR_SECOND | 8'($urandom_range(0, 15));
        p[2] = cesu_pkg::UTF8_CONT | 8'($urandom_range(0, 63));
        // The trailing half is not checked by the block, so it is sometimes junk.
        p[3] = ($urandom_range(0, 99) < 80) ? cesu_pkg::PAIR_LEAD
                                            : 8'($urandom_range(0, 255));
        p[4] = ($urandom_range(0, 99) < 80) ? (8'hB0 | 8'($urandom_range(0, 15)))
                                            : 8'($urandom_range(0, 255));
        p[5] = ($urandom_range(0, 99) < 80)
             ? (cesu_pkg::UTF8_CONT | 8'($urandom_range(0, 63)))
             : 8'($urandom_range(0, 255));
        for (int i = 0; i < keep; i++)
            frame_q.push_back(p[i]);
    endfunction

    function automatic void append_segment();
        int         r;
        logic [7:0] v;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            append_pair(6);
        end
        else if (r < 55)
        begin
            append_pair($urandom_range(1, 5));
        end
        else if (r < 65)
        begin
            v = 8'($urandom_range(0, 255));
            if ((v & cesu_pkg::HIGH_NIBBLE) == cesu_pkg::PAIR_SECOND)
                v = v ^ 8'h40;
            frame_q.push_back(cesu_pkg::PAIR_LEAD);
            frame_q.push_back(v);
        end
        else if (r < 75)
        begin
            frame_q.push_back(cesu_pkg::PAIR_LEAD);
            frame_q.push_back(cesu_pkg::PAIR_LEAD);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic test_passthrough_extremes();
        src_free  = 1'b1;
        sink_free = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        src_free  = 1'b0;
        sink_free = 1'b0;
    endtask

    // Lowest supplementary code point, 0x10000.
    task automatic test_pair_lowest();
        frame_q = '{cesu_pkg::PAIR_LEAD, 8'hA0, 8'h80, cesu_pkg::PAIR_LEAD, 8'hB0, 8'h80};
        for (int i = 0; i < 6; i++)
            send_byte(frame_q[i], 1'b0);
        frame_q.delete();
    endtask

    // Highest code point, 0x10FFFF, with junk in the unchecked trailing half,
    // and the pair completing on the final beat of the frame.
    task automatic test_pair_highest_at_end();
        frame_q = '{cesu_pkg::PAIR_LEAD, 8'hAF, 8'hBF, 8'h41, 8'hCF, 8'h7F};
        send_frame_q();
    endtask

    // A lead byte not followed by a second pair byte, once by another lead.
    task automatic test_broken_lead();
        send_byte(cesu_pkg::PAIR_LEAD, 1'b0);
        send_byte(cesu_pkg::PAIR_LEAD, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    // End of frame with two and five bytes held, then a lone lead byte.
    task automatic test_flush_held();
        frame_q = '{cesu_pkg::PAIR_LEAD, 8'hA5};
        send_frame_q();
        frame_q = '{cesu_pkg::PAIR_LEAD, 8'hA3, 8'h9C, cesu_pkg::PAIR_LEAD, 8'hB7};
        send_frame_q();
        send_byte(cesu_pkg::PAIR_LEAD, 1'b1);
    endtask

    task automatic test_random_frames(input int target);
        int r;
        bit paused;
        paused = 1'b0;
        while (bytes_sent < target)
        begin
            r = $urandom_range(0, 99);
            src_free  = (r < 15);
            sink_free = (r < 15);
            repeat ($urandom_range(1, 6))
                append_segment();
            send_frame_q();
            if (!paused && bytes_sent > target / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
        src_free  = 1'b0;
        sink_free = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough_extremes();
        test_pair_lowest();
        test_pair_highest_at_end();
        wait_drained();
        test_broken_lead();
        test_flush_held();
        wait_drained();
        test_random_frames(360);

        wait_drained();
        repeat (16) @(posedge clk);
        if (fails == 0 && utf8_expect_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
